// File: rtl/core/msqm_pkg.sv
package msqm_pkg;

  // Field widths.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned SIL_W    = 17;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned SUM_W    = 19;

  // Defaults for the top level parameters.
  localparam int unsigned LINE_MAX_DEF = 48;

  // Length of one idle tick in ms.
  localparam int unsigned TICK_MS = 10;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

  // Register reset values.
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [CFG_W-1:0] SILENCE_RST = 16'd2000;
  localparam logic [CFG_W-1:0] PAUSE_RST   = 16'd500;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SILENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAUSE   = 2'd2;

  // Line terminators.
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // Patterns, last character in the low byte. Shorter ones are padded so
  // that a character at distance d back from the newest byte is [8*d +: 8].
  localparam int unsigned PAT_W    = 56;
  localparam int unsigned UP_LEN   = 7;
  localparam int unsigned WIFI_LEN = 4;
  localparam int unsigned CONN_LEN = 7;
  localparam logic [PAT_W-1:0] PAT_UP   = "TO WIFI";
  localparam logic [PAT_W-1:0] PAT_WIFI = {24'h000000, "WIFI"};
  localparam logic [PAT_W-1:0] PAT_CONN = "CONNECT";
  localparam logic [15:0]      PAT_OK   = "OK";

  // Number of history cells: longest pattern minus the newest byte.
  localparam int unsigned WIN_CELLS = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_QUERY     = 2'd0,
    EV_CONNECTED = 2'd1,
    EV_NO_WIFI   = 2'd2,
    EV_TIMEOUT   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_PAUSE = 2'd2
  } phase_e;

  // Per cell compare results for each pattern.
  typedef struct packed {
    logic up;
    logic wifi;
    logic conn;
  } cell_hit_t;

  typedef struct packed {
    logic up;
    logic vocab;
    logic hidden;
    logic okbad;
  } line_flags_t;

  typedef struct packed {
    logic up;
    logic vocab;
  } reply_flags_t;

endpackage

// File: rtl/core/msqm_if.sv
// Input channel: one word is one event.
interface msqm_in_if;
  logic                             valid;
  logic                             ready;
  logic [msqm_pkg::KIND_W-1:0]      kind;
  logic [msqm_pkg::BYTE_W-1:0]      rx_byte;
  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

// Output channel: one word is one event code.
interface msqm_out_if;
  logic                             valid;
  logic                             ready;
  logic [msqm_pkg::EVENT_W-1:0]     event_res;
  modport source (output valid, event_res, input ready);
  modport sink   (input valid, event_res, output ready);
endinterface

// Configuration write channel.
interface msqm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [msqm_pkg::CFG_IDX_W-1:0]   index;
  logic [msqm_pkg::CFG_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/msqm_cell.sv
// One history cell: holds the byte DIST positions before the newest one and
// compares it against the pattern characters expected at that distance.
module msqm_cell #(
  parameter int unsigned DIST = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          clear_i,
  input  logic [msqm_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          valid_i,
  output logic [msqm_pkg::BYTE_W-1:0]   byte_o,
  output logic                          valid_o,
  output msqm_pkg::cell_hit_t           hit_o
);

  localparam logic [msqm_pkg::BYTE_W-1:0] UP_CH   = msqm_pkg::PAT_UP[8*DIST +: 8];
  localparam logic [msqm_pkg::BYTE_W-1:0] WIFI_CH = msqm_pkg::PAT_WIFI[8*DIST +: 8];
  localparam logic [msqm_pkg::BYTE_W-1:0] CONN_CH = msqm_pkg::PAT_CONN[8*DIST +: 8];

  logic                          valid_q, valid_d;
  logic [msqm_pkg::BYTE_W-1:0]   byte_q, byte_d;

  // Take the neighbor's byte on a shift; a line end or a new read empties the cell.
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = valid_i;
      byte_d  = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // A distance beyond a pattern's length does not constrain that pattern.
  always_comb begin
    hit_o.up   = (DIST >= msqm_pkg::UP_LEN)   || (valid_q && (byte_q == UP_CH));
    hit_o.wifi = (DIST >= msqm_pkg::WIFI_LEN) || (valid_q && (byte_q == WIFI_CH));
    hit_o.conn = (DIST >= msqm_pkg::CONN_LEN) || (valid_q && (byte_q == CONN_CH));
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/core/modem_status_query_matcher.sv
// Channel  Dir  Word                      Accepted when
// in_i     in   kind, rx_byte             valid && ready
// out_o    out  event_res                 valid && ready
// cfg_i    in   index, data               valid && ready (ready is always high)
//
// Every input word is handled in the cycle it is accepted, one word per cycle.
// A received text byte shifts a chain of six history cells; the pattern compares
// are spread over the cells, so no iterative compare loop stands in the byte path.
// Results go into a two-word output buffer; input stalls only when it is full.
// Reset is asynchronous and restores the register defaults and the idle phase.
module modem_status_query_matcher #(
  parameter int unsigned LINE_MAX = msqm_pkg::LINE_MAX_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  msqm_in_if.sink    in_i,
  msqm_out_if.source out_o,
  msqm_cfg_if.sink   cfg_i
);

  localparam int unsigned LINE_CNT_W = $clog2(LINE_MAX);
  localparam int unsigned WIN_CELLS  = msqm_pkg::WIN_CELLS;

  // Configuration registers.
  logic [msqm_pkg::CFG_W-1:0] timeout_q, timeout_d;
  logic [msqm_pkg::CFG_W-1:0] silence_lim_q, silence_lim_d;
  logic [msqm_pkg::CFG_W-1:0] pause_q, pause_d;

  // Control and time state.
  msqm_pkg::phase_e                 phase_q, phase_d;
  logic [LINE_CNT_W-1:0]            line_cnt_q, line_cnt_d;
  logic [1:0]                       ok_pos_q, ok_pos_d;
  msqm_pkg::line_flags_t            lf_q, lf_d;
  msqm_pkg::reply_flags_t           rf_q, rf_d;
  logic [msqm_pkg::SIL_W-1:0]       silence_q, silence_d;
  logic [msqm_pkg::CFG_W-1:0]       pause_left_q, pause_left_d;
  logic [msqm_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d;

  // Output buffer.
  logic [1:0]                       cnt_q, cnt_d;
  logic [msqm_pkg::EVENT_W-1:0]     slot0_q, slot0_d, slot1_q, slot1_d;

  // Decoded input.
  msqm_pkg::kind_e                  kind;
  logic [msqm_pkg::BYTE_W-1:0]      rx;
  logic                             in_fire, out_fire;
  logic                             start, tick_read, tick_pause, byte_read;
  logic                             is_eol, line_full, count_byte, feed_text;
  logic                             line_end, done_line;

  // Window chain.
  logic [msqm_pkg::BYTE_W-1:0]      win_byte [WIN_CELLS];
  logic                             win_valid [WIN_CELLS];
  msqm_pkg::cell_hit_t              win_hit [WIN_CELLS];
  logic [WIN_CELLS-1:0]             up_vec, wifi_vec, conn_vec;
  logic                             up_hit, wifi_hit, conn_hit;

  // Shared decisions.
  msqm_pkg::reply_flags_t           rf_line, rf_end;
  logic                             end_req, end_up, end_nowifi, end_retry, retry_now;
  logic                             decide, again, begin_read, go_idle, clear_line;
  logic [msqm_pkg::SUM_W-1:0]       sum;
  logic [msqm_pkg::ELAPSED_W-1:0]   e_sat, decide_elapsed;
  logic [msqm_pkg::CFG_W-1:0]       pl_next;

  // Event push.
  logic                             ev_push;
  msqm_pkg::event_e                 ev_code;

  // Handshakes.
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;
  assign in_i.ready  = (cnt_q != 2'd2);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.event_res = slot0_q;

  // Input decode.
  assign kind       = msqm_pkg::kind_e'(in_i.kind);
  assign rx         = in_i.rx_byte;
  assign start      = in_fire && (kind == msqm_pkg::KIND_START);
  assign byte_read  = in_fire && (kind == msqm_pkg::KIND_BYTE) &&
                      (phase_q == msqm_pkg::PH_READ);
  assign tick_read  = in_fire && (kind == msqm_pkg::KIND_TICK) &&
                      (phase_q == msqm_pkg::PH_READ);
  assign tick_pause = in_fire && (kind == msqm_pkg::KIND_TICK) &&
                      (phase_q == msqm_pkg::PH_PAUSE);
  assign is_eol     = (rx == msqm_pkg::CHAR_CR) || (rx == msqm_pkg::CHAR_LF);
  assign line_full  = (line_cnt_q >= LINE_CNT_W'(LINE_MAX - 1));
  assign line_end   = byte_read && is_eol;
  assign count_byte = byte_read && !is_eol && !lf_q.hidden && !line_full;
  assign feed_text  = count_byte && (rx != '0);
  assign done_line  = (ok_pos_q == 2'd2) && !lf_q.okbad;

  // History chain: cell 0 takes the newest byte, each cell hands its byte on.
  for (genvar gi = 0; gi < WIN_CELLS; gi++) begin : g_cell
    logic [msqm_pkg::BYTE_W-1:0] cell_byte_in;
    logic                        cell_valid_in;
    if (gi == 0) begin : g_head
      assign cell_byte_in  = rx;
      assign cell_valid_in = 1'b1;
    end else begin : g_link
      assign cell_byte_in  = win_byte[gi-1];
      assign cell_valid_in = win_valid[gi-1];
    end
    msqm_cell #(
      .DIST (gi + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (feed_text),
      .clear_i (clear_line),
      .byte_i  (cell_byte_in),
      .valid_i (cell_valid_in),
      .byte_o  (win_byte[gi]),
      .valid_o (win_valid[gi]),
      .hit_o   (win_hit[gi])
    );
    assign up_vec[gi]   = win_hit[gi].up;
    assign wifi_vec[gi] = win_hit[gi].wifi;
    assign conn_vec[gi] = win_hit[gi].conn;
  end

  // A pattern is found when the newest byte ends it and every cell agrees.
  assign up_hit   = (rx == msqm_pkg::PAT_UP[7:0])   && (&up_vec);
  assign wifi_hit = (rx == msqm_pkg::PAT_WIFI[7:0]) && (&wifi_vec);
  assign conn_hit = (rx == msqm_pkg::PAT_CONN[7:0]) && (&conn_vec);

  // Shared decisions for the end of a read and the end of a pause.
  always_comb begin
    rf_line.up    = rf_q.up | lf_q.up;
    rf_line.vocab = rf_q.vocab | lf_q.vocab;
    rf_end        = line_end ? rf_line : rf_q;
    end_req       = (line_end && done_line) ||
                    (tick_read && (silence_q >= {1'b0, silence_lim_q}));
    end_up        = end_req && rf_end.up;
    end_nowifi    = end_req && !rf_end.up && !rf_end.vocab;
    end_retry     = end_req && !rf_end.up && rf_end.vocab;
    retry_now     = end_retry && (pause_q == '0);
    sum           = {2'b00, elapsed_q} + {2'b00, silence_q} + {3'b000, pause_q};
    e_sat         = (sum > msqm_pkg::SUM_W'(msqm_pkg::ELAPSED_MAX)) ?
                    msqm_pkg::ELAPSED_MAX : sum[msqm_pkg::ELAPSED_W-1:0];
    pl_next       = (pause_left_q > msqm_pkg::CFG_W'(msqm_pkg::TICK_MS)) ?
                    (pause_left_q - msqm_pkg::CFG_W'(msqm_pkg::TICK_MS)) : '0;
    decide        = retry_now || (tick_pause && (pl_next == '0));
    decide_elapsed = retry_now ? e_sat : elapsed_q;
    again         = decide && (decide_elapsed < {1'b0, timeout_q});
    begin_read    = (start && (timeout_q != '0)) || again;
    go_idle       = (start && (timeout_q == '0)) || end_up || end_nowifi ||
                    (decide && !again);
    clear_line    = line_end || begin_read || start;
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    line_cnt_d   = line_cnt_q;
    ok_pos_d     = ok_pos_q;
    lf_d         = lf_q;
    rf_d         = rf_q;
    silence_d    = silence_q;
    pause_left_d = pause_left_q;
    elapsed_d    = elapsed_q;

    if (begin_read) begin
      phase_d = msqm_pkg::PH_READ;
    end else if (go_idle) begin
      phase_d = msqm_pkg::PH_IDLE;
    end else if (end_retry) begin
      phase_d = msqm_pkg::PH_PAUSE;
    end

    // Line scanning state.
    if (clear_line) begin
      line_cnt_d = '0;
      ok_pos_d   = '0;
      lf_d       = '0;
    end else if (count_byte) begin
      line_cnt_d = line_cnt_q + LINE_CNT_W'(1);
      if (rx == '0) begin
        lf_d.hidden = 1'b1;
      end else begin
        lf_d.up    = lf_q.up | up_hit;
        lf_d.vocab = lf_q.vocab | wifi_hit | conn_hit;
        if ((ok_pos_q != 2'd2) && !lf_q.okbad) begin
          if (rx == ((ok_pos_q == 2'd0) ? msqm_pkg::PAT_OK[15:8] :
                                          msqm_pkg::PAT_OK[7:0])) begin
            ok_pos_d = ok_pos_q + 2'd1;
          end else begin
            lf_d.okbad = 1'b1;
          end
        end
      end
    end

    // Reply flags and silence count of the current read.
    if (start || begin_read) begin
      rf_d      = '0;
      silence_d = '0;
    end else begin
      if (line_end) begin
        rf_d = rf_line;
      end
      if (tick_read && !end_req) begin
        silence_d = silence_q + msqm_pkg::SIL_W'(msqm_pkg::TICK_MS);
      end
    end

    // Overall time and pause countdown.
    if (start) begin
      elapsed_d    = '0;
      pause_left_d = '0;
    end else if (end_retry) begin
      elapsed_d    = e_sat;
      pause_left_d = pause_q;
    end else if (tick_pause) begin
      pause_left_d = pl_next;
    end
  end

  // Result of the accepted word.
  always_comb begin
    ev_push = 1'b0;
    ev_code = msqm_pkg::EV_QUERY;
    if (start) begin
      ev_push = 1'b1;
      ev_code = (timeout_q == '0) ? msqm_pkg::EV_TIMEOUT : msqm_pkg::EV_QUERY;
    end else if (end_up) begin
      ev_push = 1'b1;
      ev_code = msqm_pkg::EV_CONNECTED;
    end else if (end_nowifi) begin
      ev_push = 1'b1;
      ev_code = msqm_pkg::EV_NO_WIFI;
    end else if (decide) begin
      ev_push = 1'b1;
      ev_code = again ? msqm_pkg::EV_QUERY : msqm_pkg::EV_TIMEOUT;
    end
  end

  // Two-word output buffer; slot 0 is the head.
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (ev_push && out_fire) begin
      if (cnt_q == 2'd1) begin
        slot0_d = ev_code;
      end else begin
        slot0_d = slot1_q;
        slot1_d = ev_code;
      end
    end else if (out_fire) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end else if (ev_push) begin
      if (cnt_q == 2'd0) begin
        slot0_d = ev_code;
      end else begin
        slot1_d = ev_code;
      end
      cnt_d = cnt_q + 2'd1;
    end
  end

  // Configuration writes.
  always_comb begin
    timeout_d     = timeout_q;
    silence_lim_d = silence_lim_q;
    pause_d       = pause_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        msqm_pkg::CFG_IDX_TIMEOUT: timeout_d     = cfg_i.data;
        msqm_pkg::CFG_IDX_SILENCE: silence_lim_d = cfg_i.data;
        msqm_pkg::CFG_IDX_PAUSE:   pause_d       = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= msqm_pkg::TIMEOUT_RST;
      silence_lim_q <= msqm_pkg::SILENCE_RST;
      pause_q       <= msqm_pkg::PAUSE_RST;
      phase_q       <= msqm_pkg::PH_IDLE;
      line_cnt_q    <= '0;
      ok_pos_q      <= '0;
      lf_q          <= '0;
      rf_q          <= '0;
      silence_q     <= '0;
      pause_left_q  <= '0;
      elapsed_q     <= '0;
      cnt_q         <= '0;
    end else begin
      timeout_q     <= timeout_d;
      silence_lim_q <= silence_lim_d;
      pause_q       <= pause_d;
      phase_q       <= phase_d;
      line_cnt_q    <= line_cnt_d;
      ok_pos_q      <= ok_pos_d;
      lf_q          <= lf_d;
      rf_q          <= rf_d;
      silence_q     <= silence_d;
      pause_left_q  <= pause_left_d;
      elapsed_q     <= elapsed_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

`ifndef SYNTHESIS
  // The output buffer never holds more than two words.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer overflow");

  // A pause is only entered with time left and left when it runs out.
  a_pause_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == msqm_pkg::PH_PAUSE) |-> (pause_left_q != '0))
    else $error("pausing with no time left");

  // The idle phase never leads straight into a pause.
  a_idle_no_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == msqm_pkg::PH_IDLE) |=> (phase_q != msqm_pkg::PH_PAUSE))
    else $error("pause entered from idle");

  // Connected is only reported at the end of a read.
  a_conn_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_push && (ev_code == msqm_pkg::EV_CONNECTED)) |-> (phase_q == msqm_pkg::PH_READ))
    else $error("connected outside a read");

  // The line counter stops at the examined length.
  a_line_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_cnt_q <= LINE_CNT_W'(LINE_MAX - 1)) else $error("line counter overrun");
`endif

endmodule
